### design/pcbe_pkg.sv
// Shared package of the piecewise cubic Bezier evaluation unit.
// Holds the operation, status and pipeline kind codes and the point type.
// No dependencies.
package pcbe_pkg;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_POINT   = 2'd1;
    localparam logic [1:0] OP_TANGENT = 2'd2;
    localparam logic [1:0] OP_GLOBAL  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SECTION = 2'd1;
    localparam logic [1:0] ST_INDEX   = 2'd2;

    typedef logic [2:0] t_kind;
    localparam t_kind K_WRITE   = 3'd0;
    localparam t_kind K_POINT   = 3'd1;
    localparam t_kind K_TANGENT = 3'd2;
    localparam t_kind K_CLAMP   = 3'd3;
    localparam t_kind K_ZERO    = 3'd4;

    localparam int SECT_W  = 7;
    localparam int INDEX_W = 8;

    typedef logic signed [31:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

endpackage

### design/piecewise_cubic_bezier_eval_unit.sv
// Top level of the piecewise cubic Bezier evaluation unit.
// Depends on pcbe_pkg and pcbe_ram.
//
// The unit takes one transaction per cycle while the output side is ready, and returns
// one result for each, in order. Control points live in four RAM banks interleaved by
// point index, so the four points of a section are read in the same cycle; writes and
// reads happen in the same pipeline stage, so a query always sees every earlier write.
// When the output register is held, the pipeline holds with it; a new transaction is
// still taken while the first stage is empty.
module piecewise_cubic_bezier_eval_unit
    import pcbe_pkg::*;
#(
    parameter int MAX_SECTIONS    = 64,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [SECT_W-1:0]          i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [INDEX_W-1:0]         i_point_index,
    input  logic [SECT_W-1:0]          i_section,
    input  logic [PARAM_FRAC_BITS:0]   i_param,
    input  logic signed [31:0]         i_coord_x,
    input  logic signed [31:0]         i_coord_y,
    input  logic signed [31:0]         i_coord_z,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [31:0]         o_res_x,
    output logic signed [31:0]         o_res_y,
    output logic signed [31:0]         o_res_z,
    output logic [1:0]                 o_status
);
    localparam int P   = PARAM_FRAC_BITS;
    localparam int PW  = P + 1;
    localparam int MW  = 2 * PW;
    localparam int WW  = P + 4;
    localparam int PRW = 32 + WW;
    localparam int ACW = PRW + 2;
    localparam int IW  = $clog2(3 * MAX_SECTIONS + 4);
    localparam int AW  = IW - 2;
    localparam int BDEPTH = 2 ** AW;
    localparam logic [PW-1:0] ONE = PW'(1) << P;

    function automatic logic [P+1:0] rnd_u(input logic [MW+1:0] x);
        logic [MW+1:0] t;
        t = x + ((MW+2)'(1) << (P - 1));
        return t[2*P+1:P];
    endfunction

    function automatic logic signed [WW-1:0] x3(input logic signed [WW-1:0] a);
        return a + (a <<< 1);
    endfunction

    logic [SECT_W-1:0] r_section_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= SECT_W'(1);
        end else if (i_cfg_we) begin
            r_section_count <= i_cfg_data;
        end
    end

    logic adv, en1;
    assign adv = !o_valid || i_ready;

    // Stage 1: registered transaction.
    logic               r1_v;
    logic [1:0]         r1_op;
    logic [INDEX_W-1:0] r1_pidx;
    logic [SECT_W-1:0]  r1_sec;
    logic [PW-1:0]      r1_param;
    t_point             r1_pt;

    assign en1     = adv || !r1_v;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_op    <= i_op;
            r1_pidx  <= i_point_index;
            r1_sec   <= i_section;
            r1_param <= i_param;
            r1_pt    <= '{x: i_coord_x, y: i_coord_y, z: i_coord_z};
        end
    end

    logic [SECT_W-1:0]   n_eff;
    logic [PW-1:0]       p_sat;
    logic [PW+6:0]       scaled;
    logic [7:0]          g_sec;
    logic [SECT_W+1:0]   three_n;
    t_kind               n_kind;
    logic [1:0]          n_status;
    logic [SECT_W-1:0]   n_sel;
    logic [PW-1:0]       n_u;

    always_comb begin
        if (r_section_count == '0) begin
            n_eff = SECT_W'(1);
        end else if (32'(r_section_count) > MAX_SECTIONS) begin
            n_eff = SECT_W'(MAX_SECTIONS);
        end else begin
            n_eff = r_section_count;
        end
        p_sat   = (r1_param > ONE) ? ONE : r1_param;
        scaled  = (PW+7)'(p_sat) * (PW+7)'(n_eff);
        g_sec   = scaled[PW+6:P];
        three_n = {2'b00, n_eff} + {1'b0, n_eff, 1'b0};
        n_kind   = K_ZERO;
        n_status = ST_OK;
        n_sel    = n_eff;
        n_u      = p_sat;
        case (r1_op)
            OP_WRITE: begin
                n_kind   = K_WRITE;
                n_status = ({1'b0, r1_pidx} <= three_n) ? ST_OK : ST_INDEX;
            end
            OP_POINT, OP_TANGENT: begin
                if (r1_sec >= n_eff) begin
                    n_kind   = (r1_op == OP_POINT) ? K_CLAMP : K_ZERO;
                    n_status = ST_SECTION;
                end else begin
                    n_kind = (r1_op == OP_POINT) ? K_POINT : K_TANGENT;
                    n_sel  = r1_sec;
                end
            end
            OP_GLOBAL: begin
                if (g_sec >= {1'b0, n_eff}) begin
                    n_kind = K_CLAMP;
                end else begin
                    n_kind = K_POINT;
                    n_sel  = g_sec[SECT_W-1:0];
                    n_u    = {1'b0, scaled[P-1:0]};
                end
            end
            default: begin
                n_kind = K_ZERO;
            end
        endcase
    end

    // Stage 2: memory access and the quadratic terms.
    logic               r2_v;
    t_kind              r2_kind;
    logic [1:0]         r2_status;
    logic [SECT_W-1:0]  r2_sel;
    logic [PW-1:0]      r2_u;
    logic [INDEX_W-1:0] r2_pidx;
    t_point             r2_pt;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_kind   <= n_kind;
            r2_status <= n_status;
            r2_sel    <= n_sel;
            r2_u      <= n_u;
            r2_pidx   <= r1_pidx;
            r2_pt     <= r1_pt;
        end
    end

    logic [IW-1:0] base_ext, base, widx;
    logic          wr_en;
    logic [PW-1:0] v2;
    logic [MW-1:0] m_uu, m_vv, m_uv;
    t_point        rd_data [4];

    assign base_ext = IW'(r2_sel);
    assign base     = base_ext + (base_ext << 1);
    assign widx     = IW'(r2_pidx);
    assign wr_en    = adv && r2_v && (r2_kind == K_WRITE) && (r2_status == ST_OK);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]    off;
        logic [IW-1:0] ent;
        assign off = 2'(b) - base[1:0];
        assign ent = base + IW'(off);
        pcbe_ram #(.WIDTH($bits(t_point)), .DEPTH(BDEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en && (widx[1:0] == 2'(b))),
            .i_waddr (widx[IW-1:2]),
            .i_wdata (r2_pt),
            .i_re    (adv),
            .i_raddr (ent[IW-1:2]),
            .o_rdata (rd_data[b])
        );
    end

    assign v2   = ONE - r2_u;
    assign m_uu = MW'(r2_u) * MW'(r2_u);
    assign m_vv = MW'(v2) * MW'(v2);
    assign m_uv = MW'(r2_u) * MW'(v2);

    // Stage 3: weights and rotation of the bank outputs.
    logic          r3_v;
    t_kind         r3_kind;
    logic [1:0]    r3_status;
    logic [1:0]    r3_rot;
    logic [PW-1:0] r3_u, r3_v2, r3_uu, r3_vv, r3_uv;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_kind   <= r2_kind;
            r3_status <= r2_status;
            r3_rot    <= base[1:0];
            r3_u      <= r2_u;
            r3_v2     <= v2;
            r3_uu     <= PW'(rnd_u((MW+2)'(m_uu)));
            r3_vv     <= PW'(rnd_u((MW+2)'(m_vv)));
            r3_uv     <= PW'(rnd_u((MW+2)'(m_uv)));
        end
    end

    logic [MW-1:0]          t_vvv, t_uvv, t_uuv, t_uuu;
    logic signed [WW-1:0]   s_vv, s_uu, s_uv;
    logic signed [WW-1:0]   n_w [4];
    t_point                 n_d [4];

    assign t_vvv = MW'(r3_v2) * MW'(r3_vv);
    assign t_uvv = MW'(r3_u) * MW'(r3_vv);
    assign t_uuv = MW'(r3_uu) * MW'(r3_v2);
    assign t_uuu = MW'(r3_u) * MW'(r3_uu);
    assign s_vv  = $signed({3'b000, r3_vv});
    assign s_uu  = $signed({3'b000, r3_uu});
    assign s_uv  = $signed({3'b000, r3_uv});

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_w[k] = '0;
            n_d[k] = rd_data[2'(r3_rot + 2'(k))];
        end
        case (r3_kind)
            K_POINT: begin
                n_w[0] = $signed({2'b00, rnd_u((MW+2)'(t_vvv))});
                n_w[1] = $signed({2'b00, rnd_u((MW+2)'(t_uvv) + ((MW+2)'(t_uvv) << 1))});
                n_w[2] = $signed({2'b00, rnd_u((MW+2)'(t_uuv) + ((MW+2)'(t_uuv) << 1))});
                n_w[3] = $signed({2'b00, rnd_u((MW+2)'(t_uuu))});
            end
            K_TANGENT: begin
                n_w[0] = WW'(0) - x3(s_vv);
                n_w[1] = x3(s_vv - (s_uv <<< 1));
                n_w[2] = x3((s_uv <<< 1) - s_uu);
                n_w[3] = x3(s_uu);
            end
            K_CLAMP: begin
                n_w[0] = $signed(WW'(ONE));
                for (int k = 1; k < 4; k++) begin
                    n_d[k] = '0;
                end
            end
            default: begin
                for (int k = 0; k < 4; k++) begin
                    n_d[k] = '0;
                end
            end
        endcase
    end

    // Stage 4: products.
    logic                 r4_v;
    logic [1:0]           r4_status;
    logic signed [WW-1:0] r4_w [4];
    t_point               r4_d [4];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_status <= r3_status;
            r4_w      <= n_w;
            r4_d      <= n_d;
        end
    end

    logic signed [PRW-1:0] n_p [3][4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_p[0][k] = PRW'(r4_d[k].x) * PRW'(r4_w[k]);
            n_p[1][k] = PRW'(r4_d[k].y) * PRW'(r4_w[k]);
            n_p[2][k] = PRW'(r4_d[k].z) * PRW'(r4_w[k]);
        end
    end

    // Stage 5: sum, rounding and saturation.
    logic                  r5_v;
    logic [1:0]            r5_status;
    logic signed [PRW-1:0] r5_p [3][4];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_status <= r4_status;
            r5_p      <= n_p;
        end
    end

    logic signed [ACW-1:0] acc [3];
    logic signed [ACW-1:0] shr [3];
    logic signed [31:0]    n_res [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = ACW'(r5_p[c][0]) + ACW'(r5_p[c][1]) + ACW'(r5_p[c][2])
                   + ACW'(r5_p[c][3]) + (ACW'(1) <<< (P - 1));
            shr[c] = acc[c] >>> P;
            if (shr[c] > ACW'(32'sh7FFFFFFF)) begin
                n_res[c] = 32'sh7FFFFFFF;
            end else if (shr[c] < -ACW'(33'sh080000000)) begin
                n_res[c] = 32'sh80000000;
            end else begin
                n_res[c] = shr[c][31:0];
            end
        end
    end

    logic               r_out_valid;
    logic signed [31:0] r_res [3];
    logic [1:0]         r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r5_v        <= r4_v;
            r_out_valid <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res    <= n_res;
            r_status <= r5_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_res_x  = r_res[0];
    assign o_res_y  = r_res[1];
    assign o_res_z  = r_res[2];
    assign o_status = r_status;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("Result carries an unknown status code.");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_INDEX) |-> (o_res_x == 0) && (o_res_y == 0)
            && (o_res_z == 0))
        else $error("Rejected write transaction returned a nonzero result.");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |-> o_ready)
        else $error("Input not ready while the pipeline advances.");

    a_ram_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r2_v && (r2_kind == K_WRITE))
        else $error("Store written by a non-write transaction.");
endmodule

### design/pcbe_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module pcbe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### tb/tb_piecewise_cubic_bezier_eval_unit.sv
// Self-checking testbench of the piecewise cubic Bezier evaluation unit.
// Drives write and query transactions, predicts each result with a fixed-point
// curve model of its own and compares in order. Depends on pcbe_pkg and the unit.
module tb_piecewise_cubic_bezier_eval_unit
    import pcbe_pkg::*;
();

    localparam int  NSEC_MAX = 64;
    localparam int  DEPTH    = 3 * NSEC_MAX + 1;
    localparam longint ONE   = 64'sd65536;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  pidx;
        logic [6:0]  sec;
        logic [16:0] param;
        t_point      pt;
    } t_txn;

    typedef struct packed {
        t_point     pt;
        logic [1:0] status;
    } t_curve_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = '0;
    logic [7:0]  i_point_index = '0;
    logic [6:0]  i_section = '0;
    logic [16:0] i_param = '0;
    logic signed [31:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_res_x, o_res_y, o_res_z;
    logic [1:0]  o_status;

    piecewise_cubic_bezier_eval_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_op(i_op),
        .i_point_index(i_point_index), .i_section(i_section), .i_param(i_param),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .o_valid(o_valid), .i_ready(i_ready), .o_res_x(o_res_x), .o_res_y(o_res_y),
        .o_res_z(o_res_z), .o_status(o_status)
    );

    always #1 i_clk = ~i_clk;

    t_txn       pending_txns[$];
    t_curve_res expected_results[$];
    t_point     ctrl_pts[DEPTH];
    logic [6:0] sect_reg = 7'd1;
    int         mismatches = 0;
    bit         sender_idle_ok = 1'b1;
    bit         receiver_idle_ok = 1'b1;
    int         hold_cycles = 0;
    bit         pause_sender = 1'b0;

    function automatic int eff_sections();
        if (sect_reg == 0) return 1;
        if (sect_reg > NSEC_MAX) return NSEC_MAX;
        return sect_reg;
    endfunction

    function automatic longint round_q(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic t_coord sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_coord'(v);
    endfunction

    function automatic t_point blend_section(int sec, longint u, bit tangent);
        longint v, uu, vv, uv, acc;
        longint w[4];
        t_point r, p;
        v = ONE - u;
        uu = round_q(u * u);
        vv = round_q(v * v);
        uv = round_q(u * v);
        if (tangent) begin
            w[0] = -3 * vv;
            w[1] = 3 * (vv - 2 * uv);
            w[2] = 3 * (2 * uv - uu);
            w[3] = 3 * uu;
        end else begin
            w[0] = round_q(v * vv);
            w[1] = round_q(3 * u * vv);
            w[2] = round_q(3 * uu * v);
            w[3] = round_q(u * uu);
        end
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                p = ctrl_pts[sec * 3 + k];
                acc += longint'(c == 0 ? p.x : c == 1 ? p.y : p.z) * w[k];
            end
            if (c == 0) r.x = sat32(round_q(acc));
            else if (c == 1) r.y = sat32(round_q(acc));
            else r.z = sat32(round_q(acc));
        end
        return r;
    endfunction

    function automatic t_curve_res predict_curve(t_txn t);
        t_curve_res r;
        int n, s;
        longint p, scaled;
        n = eff_sections();
        p = t.param;
        if (p > ONE) p = ONE;
        r.pt = '0;
        r.status = ST_OK;
        case (t.op)
            OP_WRITE: begin
                if (t.pidx <= 3 * n) begin
                    ctrl_pts[t.pidx] = t.pt;
                end else begin
                    r.status = ST_INDEX;
                end
            end
            OP_POINT, OP_TANGENT: begin
                if (t.sec >= n) begin
                    r.status = ST_SECTION;
                    if (t.op == OP_POINT) r.pt = ctrl_pts[3 * n];
                end else begin
                    r.pt = blend_section(t.sec, p, t.op == OP_TANGENT);
                end
            end
            default: begin
                scaled = p * n;
                s = int'(scaled >>> 16);
                if (s >= n) r.pt = ctrl_pts[3 * n];
                else r.pt = blend_section(s, scaled & (ONE - 1), 1'b0);
            end
        endcase
        return r;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return t_coord'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_param();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_txn make_write(int idx);
        t_txn t;
        t.op = OP_WRITE;
        t.pidx = 8'(idx);
        t.sec = 7'($urandom);
        t.param = 17'($urandom);
        t.pt = '{rand_coord(), rand_coord(), rand_coord()};
        return t;
    endfunction

    function automatic t_txn make_query(logic [1:0] op, int sec, logic [16:0] prm);
        t_txn t;
        t.op = op;
        t.pidx = 8'($urandom);
        t.sec = 7'(sec);
        t.param = prm;
        t.pt = '{t_coord'($urandom), t_coord'($urandom), t_coord'($urandom)};
        return t;
    endfunction

    // Predicts at acceptance, so the model store follows transaction order.
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            expected_results.push_back(predict_curve('{i_op, i_point_index, i_section,
                i_param, '{i_coord_x, i_coord_y, i_coord_z}}));
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (!pause_sender && pending_txns.size() > 0
                && (!sender_idle_ok || $urandom_range(0, 99) >= 10))
            begin
                t_txn t;
                t = pending_txns.pop_front();
                i_valid <= 1'b1;
                i_op <= t.op;
                i_point_index <= t.pidx;
                i_section <= t.sec;
                i_param <= t.param;
                i_coord_x <= t.pt.x;
                i_coord_y <= t.pt.y;
                i_coord_z <= t.pt.z;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_curve_res e;
        if (o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h status=%0d", $time,
                    o_res_x, o_res_y, o_res_z, o_status);
                mismatches++;
            end else begin
                e = expected_results.pop_front();
                if (o_res_x !== e.pt.x) begin
                    $display("%0t: res_x expected %h actual %h", $time, e.pt.x, o_res_x);
                    mismatches++;
                end
                if (o_res_y !== e.pt.y) begin
                    $display("%0t: res_y expected %h actual %h", $time, e.pt.y, o_res_y);
                    mismatches++;
                end
                if (o_res_z !== e.pt.z) begin
                    $display("%0t: res_z expected %h actual %h", $time, e.pt.z, o_res_z);
                    mismatches++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                        o_status);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !receiver_idle_ok || $urandom_range(0, 99) >= 10;
        end
    end

    task automatic wait_drained();
        while (pending_txns.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_sections(logic [6:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        sect_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Loads every slot of the current curve so no unwritten point is ever read.
    task automatic load_curve();
        for (int i = 0; i <= 3 * eff_sections(); i++) pending_txns.push_back(make_write(i));
    endtask

    // A mostly well-formed random phase: queries, with rewrites and bad writes mixed in.
    task automatic random_phase(int count);
        int n, k;
        for (int i = 0; i < count; i++) begin
            n = eff_sections();
            k = $urandom_range(0, 99);
            if (k < 15) begin
                pending_txns.push_back(make_write($urandom_range(0, 3 * n)));
            end else if (k < 20) begin
                pending_txns.push_back(make_write($urandom_range(3 * n + 1, 255)));
            end else if (k < 45) begin
                pending_txns.push_back(make_query(OP_POINT, $urandom_range(0, 99) < 85 ?
                    $urandom_range(0, n - 1) : $urandom_range(n, 127), rand_param()));
            end else if (k < 70) begin
                pending_txns.push_back(make_query(OP_TANGENT, $urandom_range(0, 99) < 85 ?
                    $urandom_range(0, n - 1) : $urandom_range(n, 127), rand_param()));
            end else begin
                pending_txns.push_back(make_query(OP_GLOBAL, $urandom_range(0, 127),
                    rand_param()));
            end
        end
    endtask

    initial begin
        logic [6:0] settings[6];
        settings = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd17};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_curve();
        pending_txns.push_back(make_write(4));
        pending_txns.push_back(make_write(255));
        pending_txns.push_back(make_query(OP_POINT, 0, 17'd0));
        pending_txns.push_back(make_query(OP_POINT, 0, 17'd65536));
        pending_txns.push_back(make_query(OP_POINT, 0, 17'h1ffff));
        pending_txns.push_back(make_query(OP_POINT, 0, 17'd32768));
        pending_txns.push_back(make_query(OP_POINT, 1, 17'd100));
        pending_txns.push_back(make_query(OP_POINT, 127, 17'd100));
        pending_txns.push_back(make_query(OP_TANGENT, 0, 17'd0));
        pending_txns.push_back(make_query(OP_TANGENT, 0, 17'd65536));
        pending_txns.push_back(make_query(OP_TANGENT, 0, 17'd12345));
        pending_txns.push_back(make_query(OP_TANGENT, 3, 17'd12345));
        pending_txns.push_back(make_query(OP_GLOBAL, 0, 17'd0));
        pending_txns.push_back(make_query(OP_GLOBAL, 0, 17'd65536));
        pending_txns.push_back(make_query(OP_GLOBAL, 0, 17'd65535));
        pending_txns.push_back(make_query(OP_GLOBAL, 0, 17'h10000 | 17'd7));
        wait_drained();

        for (int s = 1; s < 6; s++) begin
            write_sections(settings[s]);
            load_curve();
            sender_idle_ok = (s != 2);
            receiver_idle_ok = (s != 2);
            random_phase(s == 1 || s == 3 ? 220 : 280);
            if (s == 4) begin
                hold_cycles <= 300;
            end
            wait_drained();
            if (s == 3) begin
                pause_sender = 1'b1;
                wait_drained();
                pause_sender = 1'b0;
            end
        end
        sender_idle_ok = 1'b1;
        receiver_idle_ok = 1'b1;
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
